FILE: sv/lrc_pkg.sv
// Shared types and constants for the LRU lookup cache.
// Used by lrc_order, lru_lookup_cache and the testbench; depends on nothing else.
package lrc_pkg;

    // Default geometry of the cache.
    localparam int SLOTS_DEF      = 8;
    localparam int KEY_BITS_DEF   = 32;
    localparam int TABLE_BITS_DEF = 16;
    localparam int REF_BITS_DEF   = 16;

    // Fixed result field widths.
    localparam int FOUND_REF_W = 16;
    localparam int COUNT_W     = 32;
    localparam int M_DATA_W    = ((FOUND_REF_W + 2 * COUNT_W + 7) / 8) * 8;

    // Request kinds carried on s_tuser.
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } lrc_state_t;

endpackage

FILE: sv/lru_lookup_cache.sv
// Top level of the fully associative LRU lookup cache.
// Depends on lrc_pkg and lrc_order; holds the slot memory and the scan control.
//
//  channel  | direction | tdata (low bit first)                 | tuser
//  ---------+-----------+---------------------------------------+----------
//  s_       | in        | table_id, key_tag, entry_ref, zero pad | req_type
//  m_       | out       | found_ref, hit_count, miss_count       | hit
//
// The slot memory has a single read port, so the scan reads one slot per
// cycle. Slot 0 is read in the cycle the beat is taken, and the final cycle
// compares the last slot and writes the recency order, memory and counters.
// A new request beat is taken in that final cycle, so requests follow each
// other with no gap. Inserts produce no result beat. A lookup whose result
// cannot be loaded because the previous result beat is still unclaimed holds
// in its final cycle until m_tready frees the output register. Reset clears
// the valid flags and counters at once; the slot memory is not swept.
module lru_lookup_cache import lrc_pkg::*; #(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int TABLE_BITS = TABLE_BITS_DEF,
    parameter int REF_BITS   = REF_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Request channel.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // table_id, key_tag, entry_ref, zero padding up to whole bytes
    input  logic [((TABLE_BITS + KEY_BITS + REF_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // req_type
    input  logic [0:0]              s_tuser,
    // Result channel.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // found_ref, hit_count, miss_count
    output logic [M_DATA_W-1:0]     m_tdata,
    // hit
    output logic [0:0]              m_tuser
);

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ENTRY_W = TABLE_BITS + KEY_BITS + REF_BITS;
    localparam int KEY_LO  = TABLE_BITS;
    localparam int REF_LO  = TABLE_BITS + KEY_BITS;
    localparam logic [SLOT_W-1:0] RANK_LAST = SLOT_W'(SLOTS - 1);

    // Control state.
    lrc_state_t state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg;

    // Request being worked on.
    logic                  req_type_reg;
    logic [TABLE_BITS-1:0] tbl_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [REF_BITS-1:0]   ref_reg;

    // Slot memory and its read side.
    logic [ENTRY_W-1:0] mem [SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0]  rd_slot_reg;
    logic               rd_vld_reg;
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;

    // Best candidate found so far in the scan.
    logic                best_found_reg;
    logic [SLOT_W-1:0]   best_slot_reg;
    logic [SLOT_W-1:0]   best_rank_reg;
    logic [REF_BITS-1:0] best_ref_reg;
    logic                cur_found;
    logic [SLOT_W-1:0]   cur_slot;
    logic [SLOT_W-1:0]   cur_rank;
    logic [REF_BITS-1:0] cur_ref;
    logic                hit_now;
    logic                better;

    logic [SLOT_W-1:0] rank_at;
    logic              valid_at;

    // Counters and output register.
    logic [COUNT_W-1:0]     hits_reg;
    logic [COUNT_W-1:0]     misses_reg;
    logic                   m_valid_reg;
    logic                   m_hit_reg;
    logic [FOUND_REF_W-1:0] m_ref_reg;
    logic [COUNT_W-1:0]     m_hits_reg;
    logic [COUNT_W-1:0]     m_misses_reg;

    logic accept;
    logic can_finish;
    logic finish;
    logic is_insert;

    assign is_insert = (req_type_reg == REQ_INSERT);
    assign accept    = s_tvalid && s_tready;

    // A lookup may only finish once the output register is free or is being
    // drained in the same cycle; an insert never needs it.
    assign can_finish = is_insert || !m_valid_reg || m_tready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == RANK_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (can_finish) begin
                    state_next = accept ? ST_SCAN : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs: a new request is taken when idle, or in the final cycle
    // of the previous one, and its first slot read starts at once.
    always_comb begin
        s_tready = 1'b0;
        finish   = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                rd_en    = s_tvalid;
            end
            ST_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            ST_FINISH: begin
                finish   = can_finish;
                s_tready = can_finish;
                rd_en    = can_finish && s_tvalid;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                idx_reg <= SLOT_W'(1);
            end else if (state_reg == ST_SCAN) begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_type_reg <= s_tuser[0];
            tbl_reg      <= s_tdata[TABLE_BITS-1:0];
            key_reg      <= s_tdata[KEY_LO +: KEY_BITS];
            ref_reg      <= s_tdata[REF_LO +: REF_BITS];
        end
    end

    // Slot memory. An insert written in the final cycle can land on the slot
    // that the next request reads first, so the written entry is forwarded.
    assign wr_en   = finish && is_insert;
    assign wr_data = {ref_reg, key_reg, tbl_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cur_slot] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= (wr_en && (cur_slot == rd_addr)) ? wr_data : mem[rd_addr];
            rd_slot_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
        end
    end

    lrc_order #(
        .SLOTS (SLOTS)
    ) u_order (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rd_slot       (rd_slot_reg),
        .rank_at       (rank_at),
        .valid_at      (valid_at),
        .upd_en        (finish && cur_found),
        .upd_set_valid (is_insert),
        .upd_slot      (cur_slot),
        .upd_rank      (cur_rank)
    );

    // Per-slot compare. A lookup looks for a valid slot with the same table
    // and key; an insert looks for the least recent slot. Among several
    // matches the lowest rank wins.
    always_comb begin
        if (is_insert) begin
            hit_now = rd_vld_reg && (rank_at == RANK_LAST);
        end else begin
            hit_now = rd_vld_reg && valid_at
                      && (rd_data_reg[TABLE_BITS-1:0] == tbl_reg)
                      && (rd_data_reg[KEY_LO +: KEY_BITS] == key_reg);
        end
        better    = hit_now && (!best_found_reg || (rank_at < best_rank_reg));
        cur_found = best_found_reg || hit_now;
        cur_slot  = better ? rd_slot_reg : best_slot_reg;
        cur_rank  = better ? rank_at : best_rank_reg;
        cur_ref   = better ? rd_data_reg[REF_LO +: REF_BITS] : best_ref_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg <= 1'b0;
        end else if (accept) begin
            best_found_reg <= 1'b0;
        end else begin
            best_found_reg <= cur_found;
        end
    end

    always_ff @(posedge aclk) begin
        best_slot_reg <= cur_slot;
        best_rank_reg <= cur_rank;
        best_ref_reg  <= cur_ref;
    end

    // Counters and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_reg    <= '0;
            misses_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (finish && !is_insert) begin
                m_valid_reg <= 1'b1;
                if (cur_found) begin
                    hits_reg <= hits_reg + COUNT_W'(1);
                end else begin
                    misses_reg <= misses_reg + COUNT_W'(1);
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (finish && !is_insert) begin
            m_hit_reg    <= cur_found;
            m_ref_reg    <= cur_found ? FOUND_REF_W'(cur_ref) : '0;
            m_hits_reg   <= cur_found ? hits_reg + COUNT_W'(1) : hits_reg;
            m_misses_reg <= cur_found ? misses_reg : misses_reg + COUNT_W'(1);
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = M_DATA_W'({m_misses_reg, m_hits_reg, m_ref_reg});
    assign m_tuser[0] = m_hit_reg;

    // No request is taken while a scan is under way.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !s_tready)
        else $error("request taken during slot scan");

    // A new result beat only follows the completion of a lookup.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(finish && (req_type_reg == REQ_LOOKUP)))
        else $error("result beat without a finished lookup");

    // The hit counter advances by at most one per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (hits_reg != $past(hits_reg)) |-> (hits_reg == $past(hits_reg) + COUNT_W'(1)))
        else $error("hit counter jumped");

    // Exactly one of the counters moves when a lookup completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && !is_insert) |=>
            ((hits_reg != $past(hits_reg)) != (misses_reg != $past(misses_reg))))
        else $error("lookup did not update exactly one counter");

endmodule

FILE: sv/lrc_order.sv
// Recency order and valid flags of the cache slots, kept in flip-flops.
// Depends on lrc_pkg; instantiated by lru_lookup_cache.
module lrc_order import lrc_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [$clog2(SLOTS)-1:0]   rd_slot,
    output logic [$clog2(SLOTS)-1:0]   rank_at,
    output logic                       valid_at,
    input  logic                       upd_en,
    input  logic                       upd_set_valid,
    input  logic [$clog2(SLOTS)-1:0]   upd_slot,
    input  logic [$clog2(SLOTS)-1:0]   upd_rank
);

    localparam int SLOT_W = $clog2(SLOTS);

    logic [SLOT_W-1:0] rank_reg [SLOTS];
    logic [SLOTS-1:0]  valid_reg;

    assign rank_at  = rank_reg[rd_slot];
    assign valid_at = valid_reg[rd_slot];

    // Promotion: the chosen slot becomes rank 0 and every slot that was more
    // recent than it moves one place toward the old end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                rank_reg[i] <= SLOT_W'(i);
            end
        end else if (upd_en) begin
            if (upd_set_valid) begin
                valid_reg[upd_slot] <= 1'b1;
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (SLOT_W'(i) == upd_slot) begin
                    rank_reg[i] <= '0;
                end else if (rank_reg[i] < upd_rank) begin
                    rank_reg[i] <= rank_reg[i] + SLOT_W'(1);
                end
            end
        end
    end

endmodule

FILE: verif/lrc_result_checker.sv
// Result checker for the LRU lookup cache: watches both stream channels,
// keeps its own copy of the slot contents and recency order, and compares
// every result beat. Depends on lrc_pkg for widths and request kinds.
module lrc_result_checker import lrc_pkg::*; #(
    parameter int S_DATA_W = ((TABLE_BITS_DEF + KEY_BITS_DEF + REF_BITS_DEF + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // table_id, key_tag, entry_ref, zero padding
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type
    input  logic [0:0]          s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // found_ref, hit_count, miss_count
    input  logic [M_DATA_W-1:0] m_tdata,
    // hit
    input  logic [0:0]          m_tuser,
    output int                  fail_count,
    output int                  answers_pending,
    output int                  inserts_seen,
    output int                  lookups_seen,
    output int                  hits_seen
);

    localparam int RANK_W     = $clog2(SLOTS_DEF);

    typedef struct packed {
        logic                   hit;
        logic [FOUND_REF_W-1:0] found_ref;
        logic [COUNT_W-1:0]     hit_count;
        logic [COUNT_W-1:0]     miss_count;
    } lookup_answer_t;

    logic                      slot_used [SLOTS_DEF];
    logic [TABLE_BITS_DEF-1:0] slot_tbl  [SLOTS_DEF];
    logic [KEY_BITS_DEF-1:0]   slot_key  [SLOTS_DEF];
    logic [REF_BITS_DEF-1:0]   slot_eref [SLOTS_DEF];
    logic [RANK_W-1:0]         slot_age  [SLOTS_DEF];
    logic [COUNT_W-1:0]        hits_so_far;
    logic [COUNT_W-1:0]        misses_so_far;
    lookup_answer_t            answer_queue [$];
    lookup_answer_t            want;

    function automatic void clear_cache();
        for (int i = 0; i < SLOTS_DEF; i++) begin
            slot_used[i] = 1'b0;
            slot_tbl[i]  = '0;
            slot_key[i]  = '0;
            slot_eref[i] = '0;
            slot_age[i]  = RANK_W'(i);
        end
        hits_so_far   = '0;
        misses_so_far = '0;
        answer_queue.delete();
        fail_count   = 0;
        inserts_seen = 0;
        lookups_seen = 0;
        hits_seen    = 0;
    endfunction

    // Age 0 is the most recent slot; everything younger than s ages by one.
    function automatic void make_most_recent(int s);
        logic [RANK_W-1:0] old_age;
        old_age = slot_age[s];
        for (int i = 0; i < SLOTS_DEF; i++)
            if (slot_age[i] < old_age)
                slot_age[i] = slot_age[i] + 1'b1;
        slot_age[s] = '0;
    endfunction

    function automatic void apply_request(logic kind, logic [TABLE_BITS_DEF-1:0] tbl,
                                          logic [KEY_BITS_DEF-1:0] key,
                                          logic [REF_BITS_DEF-1:0] eref);
        int             victim;
        int             best;
        bit             found;
        lookup_answer_t ans;
        if (kind == REQ_INSERT) begin
            // The oldest slot is replaced, valid or not, duplicates allowed.
            victim = 0;
            for (int i = 0; i < SLOTS_DEF; i++)
                if (slot_age[i] == RANK_W'(SLOTS_DEF - 1))
                    victim = i;
            slot_used[victim] = 1'b1;
            slot_tbl[victim]  = tbl;
            slot_key[victim]  = key;
            slot_eref[victim] = eref;
            make_most_recent(victim);
            inserts_seen++;
        end else begin
            found = 1'b0;
            best  = 0;
            for (int i = 0; i < SLOTS_DEF; i++) begin
                if (slot_used[i] && slot_tbl[i] == tbl && slot_key[i] == key) begin
                    if (!found || slot_age[i] < slot_age[best]) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            ans.hit       = found;
            ans.found_ref = '0;
            if (found) begin
                hits_so_far   = hits_so_far + 1'b1;
                ans.found_ref = FOUND_REF_W'(slot_eref[best]);
                make_most_recent(best);
                hits_seen++;
            end else begin
                misses_so_far = misses_so_far + 1'b1;
            end
            ans.hit_count  = hits_so_far;
            ans.miss_count = misses_so_far;
            answer_queue.push_back(ans);
            lookups_seen++;
        end
    endfunction

    function automatic void check_field(string field, logic [COUNT_W-1:0] expected_val,
                                        logic [COUNT_W-1:0] actual_val);
        if (actual_val !== expected_val) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, expected_val, actual_val);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_cache();
        end else begin
            if (m_tvalid && m_tready) begin
                if (answer_queue.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with none expected, actual hit %0b data %0h",
                             $time, m_tuser[0], m_tdata);
                end else begin
                    want = answer_queue.pop_front();
                    check_field("hit", COUNT_W'(want.hit), COUNT_W'(m_tuser[0]));
                    check_field("found_ref", COUNT_W'(want.found_ref),
                                COUNT_W'(m_tdata[FOUND_REF_W-1:0]));
                    check_field("hit_count", want.hit_count,
                                m_tdata[FOUND_REF_W +: COUNT_W]);
                    check_field("miss_count", want.miss_count,
                                m_tdata[FOUND_REF_W + COUNT_W +: COUNT_W]);
                end
            end
            if (s_tvalid && s_tready)
                apply_request(s_tuser[0], s_tdata[TABLE_BITS_DEF-1:0],
                              s_tdata[TABLE_BITS_DEF +: KEY_BITS_DEF],
                              s_tdata[TABLE_BITS_DEF + KEY_BITS_DEF +: REF_BITS_DEF]);
        end
        answers_pending = answer_queue.size();
    end

endmodule

FILE: verif/tb_lru_lookup_cache.sv
// Top of the LRU lookup cache testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on lrc_pkg, lru_lookup_cache
// and lrc_result_checker, which does all prediction and comparison.
module tb_lru_lookup_cache;
    import lrc_pkg::*;

    localparam int S_DATA_W     = ((TABLE_BITS_DEF + KEY_BITS_DEF + REF_BITS_DEF + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 550;
    // A stall of the result side or a sender gap can lengthen a request; the
    // limit lies many times above the longest time a request can take.
    localparam int IDLE_LIMIT   = 200;
    localparam int DRAIN_CYCLES = 3 * (SLOTS_DEF + 1);

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    // table_id, key_tag, entry_ref, zero padding
    logic [S_DATA_W-1:0] s_tdata;
    // req_type
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // found_ref, hit_count, miss_count
    logic [M_DATA_W-1:0] m_tdata;
    // hit
    logic [0:0]          m_tuser;

    // Cleared when the sender and receiver should run without any idling.
    bit idle_on;

    int fail_count;
    int answers_pending;
    int inserts_seen;
    int lookups_seen;
    int hits_seen;

    lru_lookup_cache i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lrc_result_checker #(.S_DATA_W(S_DATA_W)) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .answers_pending (answers_pending),
        .inserts_seen    (inserts_seen),
        .lookups_seen    (lookups_seen),
        .hits_seen       (hits_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sends one request beat. Inputs change only on the falling edge, and the
    // task returns at the rising edge where the beat is taken. tvalid stays
    // high into the next call unless that call opens a gap first, so it is
    // never lowered and raised within one time step.
    task automatic send_request(input logic kind, input logic [TABLE_BITS_DEF-1:0] tbl,
                                input logic [KEY_BITS_DEF-1:0] key,
                                input logic [REF_BITS_DEF-1:0] eref);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {eref, key, tbl};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Result side back-pressure: random bursts of stalled cycles, always
    // followed by a return to ready so that a beat can drain.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b1;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (!m_tready) begin
                m_tready = 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(0, 2);
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either channel for too long.
    // This also catches lookups whose result never arrives.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [TABLE_BITS_DEF-1:0] pool_tbl [2];
        logic [KEY_BITS_DEF-1:0]   pool_key [6];
        logic                      kind;
        logic [TABLE_BITS_DEF-1:0] tbl;
        logic [KEY_BITS_DEF-1:0]   key;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_LOOKUP;
        idle_on  = 1'b1;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. Lookups straight after reset must miss, including the
        // all-zero id and tag, since no slot is valid yet.
        send_request(REQ_LOOKUP, '0, '0, '0);
        send_request(REQ_LOOKUP, '1, '1, '1);
        send_request(REQ_INSERT, '0, '0, '0);
        send_request(REQ_INSERT, '1, '1, '1);
        // The first lookup promotes an older slot; the second hits the slot
        // that is already most recent, which leaves the order alone.
        send_request(REQ_LOOKUP, '0, '0, '1);
        send_request(REQ_LOOKUP, '0, '0, '0);
        send_request(REQ_LOOKUP, '1, '1, '0);
        // A duplicate insert: the newer copy must win the next lookup.
        send_request(REQ_INSERT, '0, '0, 16'h5A5A);
        send_request(REQ_LOOKUP, '0, '0, '0);
        // Half matches on id or tag alone must miss.
        send_request(REQ_LOOKUP, '0, '1, '0);
        send_request(REQ_LOOKUP, '1, '0, '0);
        // Enough inserts to fill every slot and evict valid entries.
        for (int i = 1; i <= SLOTS_DEF; i++)
            send_request(REQ_INSERT, TABLE_BITS_DEF'(i), 32'h1357_9BDF * i,
                         REF_BITS_DEF'(16'h1111 * i));
        send_request(REQ_LOOKUP, '1, '1, '0);
        send_request(REQ_LOOKUP, '0, '0, '0);
        send_request(REQ_LOOKUP, TABLE_BITS_DEF'(1), 32'h1357_9BDF, '0);
        send_request(REQ_LOOKUP, TABLE_BITS_DEF'(SLOTS_DEF), 32'h1357_9BDF * SLOTS_DEF, '0);

        // Random part. Most requests draw their id and tag from a small pool,
        // so lookups hit, duplicates build up and evictions matter; the rest
        // are fully random. The pool is redrawn now and then so that every
        // bit of the id and tag sees both values.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 137 == 0) begin
                foreach (pool_tbl[i])
                    pool_tbl[i] = TABLE_BITS_DEF'($urandom);
                foreach (pool_key[i])
                    pool_key[i] = $urandom;
            end
            idle_on = !((n >= 200 && n < 260) || n >= RANDOM_ITEMS - 100);
            kind    = ($urandom_range(0, 9) < 4) ? REQ_INSERT : REQ_LOOKUP;
            if ($urandom_range(0, 99) < 15) begin
                tbl = TABLE_BITS_DEF'($urandom);
                key = $urandom;
            end else begin
                tbl = pool_tbl[$urandom_range(0, 1)];
                key = pool_key[$urandom_range(0, 5)];
            end
            send_request(kind, tbl, key, REF_BITS_DEF'($urandom_range(0, 16'hFFFF)));
        end

        @(negedge aclk);
        s_tvalid = 1'b0;

        // Wait for every predicted result, then a few request times more so
        // that a stray extra beat would still be seen by the checker.
        while (answers_pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d requests: %0d inserts and %0d lookups, %0d of them hits.",
                 inserts_seen + lookups_seen, inserts_seen, lookups_seen, hits_seen);
        $display("Results were checked in order against a recency model under random stalls.");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/lrc_pkg.sv
sv/lrc_order.sv
sv/lru_lookup_cache.sv
verif/lrc_result_checker.sv
verif/tb_lru_lookup_cache.sv
